[rtl/kaac_pkg.sv]
// Package for the keypad alarm access controller.
// Transfer structs, state encodings and timing constants; no dependencies.
`timescale 1ns / 1ps

package kaac_pkg;

  // Input item: one event.
  typedef struct packed {
    logic [2:0] action;
    logic [3:0] key_value;
  } in_item_t;

  // Result item, one per event.
  typedef struct packed {
    logic [1:0] mode_now;
    logic [1:0] lamp_mode;
    logic [9:0] flash_interval_ms;
    logic       sound_on;
    logic       alarm_raise;
    logic       countdown_start;
    logic [1:0] sound_timer_cmd;
    logic [9:0] sound_timer_ms;
    logic       prompt_update;
    logic [2:0] prompt_digits;
    logic       granted_message;
    logic       leave_accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_CODE    = 2'd1,
    MODE_ALARM   = 2'd2,
    MODE_GRANTED = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_IGNORE   = 3'd0,
    PH_INPUT    = 3'd1,
    PH_KEYBEEP  = 3'd2,
    PH_CODEBEEP = 3'd3,
    PH_ERRBEEP  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    LAMP_OFF    = 2'd0,
    LAMP_FLASH  = 2'd1,
    LAMP_STEADY = 2'd2
  } lamp_t;

  // Event codes
  localparam logic [2:0] ACT_ENTER  = 3'd0;
  localparam logic [2:0] ACT_LEAVE  = 3'd1;
  localparam logic [2:0] ACT_EXPIRE = 3'd2;
  localparam logic [2:0] ACT_KEY    = 3'd3;
  localparam logic [2:0] ACT_SOUND  = 3'd4;

  // Sound timer commands
  localparam logic [1:0] SND_NONE     = 2'd0;
  localparam logic [1:0] SND_ONESHOT  = 2'd1;
  localparam logic [1:0] SND_PERIODIC = 2'd2;
  localparam logic [1:0] SND_STOP     = 2'd3;

  // Timing, milliseconds
  localparam logic [9:0] FLASH_START_MS = 10'd1000;
  localparam logic [9:0] FLASH_STEP_MS  = 10'd250;
  localparam logic [9:0] FLASH_ALARM_MS = 10'd200;
  localparam logic [9:0] BEEP_KEY_MS    = 10'd300;
  localparam logic [9:0] BEEP_CODE_MS   = 10'd1000;
  localparam logic [9:0] BEEP_ERR_MS    = 10'd200;

  localparam logic [1:0] MAX_EXPIRY     = 2'd3;
  localparam logic [2:0] ERR_BEEP_STEPS = 3'd5;

  // Code digit storage
  localparam int         MAX_DIGITS  = 4;
  localparam int         DIG_IDX_W   = 2;
  localparam logic [15:0] CODE_RESET = 16'h4321;

  // Configuration register map (word index)
  localparam logic REG_ACCESS_CODE = 1'b0;

endpackage

[rtl/keypad_alarm_access_controller.sv]
// Keypad alarm access controller: each event (enter, leave, countdown expiry,
// key press, sound timer expiry) is captured in an input register, applied to
// the controller state and yields exactly one result in the output register.
// One event per cycle is sustained while the consumer takes each result; the
// core stalls while a result waits unread. The access code register sits
// at byte address 0 of the APB port. Depends on kaac_pkg, kaac_core, kaac_out_reg.
`timescale 1ns / 1ps

module keypad_alarm_access_controller #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  kaac_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kaac_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import kaac_pkg::*;

  logic        in_q_valid;
  in_item_t    in_q_data;
  logic [15:0] access_code;
  logic        res_space;
  logic        step;
  out_item_t   result;

  assign step     = in_q_valid && res_space;
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_data <= in_data;
    end
  end

  // Config port; byte offset bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ACCESS_CODE) ? {16'd0, access_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      access_code <= CODE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_ACCESS_CODE)) begin
      access_code <= pwdata[15:0];
    end
  end

  kaac_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (in_q_data),
    .access_code (access_code),
    .result      (result)
  );

  kaac_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .load_data (result),
    .space     (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("state update without a result");

  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.alarm_raise) |-> (out_data.mode_now == 2'(MODE_ALARM)))
    else $error("alarm raised outside alarm mode");

  a_granted_lamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.granted_message) |->
      ((out_data.mode_now == 2'(MODE_GRANTED)) && (out_data.lamp_mode == 2'(LAMP_STEADY))))
    else $error("grant without granted mode and steady lamp");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.leave_accepted) |->
      ((out_data.mode_now == 2'(MODE_IDLE)) && (out_data.lamp_mode == 2'(LAMP_OFF))))
    else $error("leave accepted without returning to idle");
`endif

endmodule

[rtl/kaac_core.sv]
// Controller state and single-pass event update for the keypad alarm block.
// Depends on kaac_pkg.
`timescale 1ns / 1ps

module kaac_core #(
  parameter int CODE_LENGTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  kaac_pkg::in_item_t item,
  input  logic [15:0]        access_code,
  output kaac_pkg::out_item_t result
);
  import kaac_pkg::*;

  localparam logic [2:0] CODE_LEN = 3'(CODE_LENGTH);

  mode_t      mode, mode_next;
  phase_t     phase, phase_next;
  lamp_t      lamp, lamp_next;
  logic [1:0] expiry_count, expiry_count_next;
  logic [2:0] phase_count, phase_count_next;
  logic [9:0] flash_period, flash_period_next;
  logic       sound, sound_next;
  logic [3:0] digits [MAX_DIGITS];

  logic       key_ok;
  logic [2:0] pc_inc;
  logic       code_done;
  logic       match;
  logic [9:0] flash_dec;

  assign key_ok    = (item.action == ACT_KEY) && (phase == PH_INPUT);
  assign pc_inc    = phase_count + 3'd1;
  assign code_done = (pc_inc >= CODE_LEN);
  assign flash_dec = (flash_period >= FLASH_STEP_MS) ? flash_period - FLASH_STEP_MS : 10'd0;

  // Compare with the new key already in place.
  always_comb begin
    logic [3:0] d;
    match = 1'b1;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      d = (phase_count[DIG_IDX_W-1:0] == DIG_IDX_W'(i)) ? item.key_value : digits[i];
      if ((i < CODE_LENGTH) && (d != access_code[4*i +: 4])) begin
        match = 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    mode_next         = mode;
    phase_next        = phase;
    lamp_next         = lamp;
    expiry_count_next = expiry_count;
    phase_count_next  = phase_count;
    flash_period_next = flash_period;
    sound_next        = sound;
    unique case (item.action)
      ACT_ENTER: begin
        if (mode == MODE_IDLE) begin
          expiry_count_next = 2'd0;
          mode_next         = MODE_CODE;
          flash_period_next = FLASH_START_MS;
          lamp_next         = LAMP_FLASH;
          phase_next        = PH_INPUT;
          phase_count_next  = 3'd0;
        end
      end
      ACT_LEAVE: begin
        if (mode == MODE_GRANTED) begin
          mode_next = MODE_IDLE;
          lamp_next = LAMP_OFF;
        end
      end
      ACT_EXPIRE: begin
        if (mode == MODE_CODE) begin
          if (expiry_count < MAX_EXPIRY) begin
            expiry_count_next = expiry_count + 2'd1;
            flash_period_next = flash_dec;
          end else begin
            mode_next         = MODE_ALARM;
            flash_period_next = FLASH_ALARM_MS;
          end
        end
      end
      ACT_KEY: begin
        if (key_ok) begin
          phase_count_next = pc_inc;
          sound_next       = 1'b1;
          if (code_done && match) begin
            mode_next  = MODE_GRANTED;
            lamp_next  = LAMP_STEADY;
            phase_next = PH_CODEBEEP;
          end else if (code_done) begin
            phase_next       = PH_ERRBEEP;
            phase_count_next = 3'd0;
          end else begin
            phase_next = PH_KEYBEEP;
          end
        end
      end
      ACT_SOUND: begin
        if (phase == PH_ERRBEEP) begin
          phase_count_next = pc_inc;
          sound_next       = ~pc_inc[0];
          if (pc_inc == ERR_BEEP_STEPS) begin
            phase_next       = PH_INPUT;
            phase_count_next = 3'd0;
          end
        end else if (phase == PH_KEYBEEP) begin
          sound_next = 1'b0;
          phase_next = PH_INPUT;
        end else if (phase == PH_CODEBEEP) begin
          sound_next = 1'b0;
          phase_next = PH_IGNORE;
        end
      end
      default: begin
      end
    endcase
  end

  // Result: levels after the update plus this event's pulses
  always_comb begin
    result                   = '0;
    result.mode_now          = mode_next;
    result.lamp_mode         = lamp_next;
    result.flash_interval_ms = flash_period_next;
    result.sound_on          = sound_next;
    unique case (item.action)
      ACT_ENTER: begin
        if (mode == MODE_IDLE) begin
          result.countdown_start = 1'b1;
          result.prompt_update   = 1'b1;
        end
      end
      ACT_LEAVE: begin
        result.leave_accepted = (mode == MODE_GRANTED);
      end
      ACT_EXPIRE: begin
        if (mode == MODE_CODE) begin
          result.countdown_start = (expiry_count < MAX_EXPIRY);
          result.alarm_raise     = (expiry_count >= MAX_EXPIRY);
        end
      end
      ACT_KEY: begin
        if (key_ok) begin
          if (code_done && match) begin
            result.granted_message = 1'b1;
            result.sound_timer_cmd = SND_ONESHOT;
            result.sound_timer_ms  = BEEP_CODE_MS;
          end else if (code_done) begin
            result.prompt_update   = 1'b1;
            result.sound_timer_cmd = SND_PERIODIC;
            result.sound_timer_ms  = BEEP_ERR_MS;
          end else begin
            result.prompt_update   = 1'b1;
            result.prompt_digits   = pc_inc;
            result.sound_timer_cmd = SND_ONESHOT;
            result.sound_timer_ms  = BEEP_KEY_MS;
          end
        end
      end
      ACT_SOUND: begin
        if ((phase == PH_ERRBEEP) && (pc_inc == ERR_BEEP_STEPS)) begin
          result.sound_timer_cmd = SND_STOP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      phase        <= PH_IGNORE;
      lamp         <= LAMP_OFF;
      expiry_count <= 2'd0;
      phase_count  <= 3'd0;
      flash_period <= FLASH_START_MS;
      sound        <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      phase        <= phase_next;
      lamp         <= lamp_next;
      expiry_count <= expiry_count_next;
      phase_count  <= phase_count_next;
      flash_period <= flash_period_next;
      sound        <= sound_next;
    end
  end

  // Digit store has no reset; only written entries are compared.
  always_ff @(posedge clk) begin
    if (step && key_ok) begin
      digits[phase_count[DIG_IDX_W-1:0]] <= item.key_value;
    end
  end

endmodule

[rtl/kaac_out_reg.sv]
// Result register with valid/ready toward the consumer.
// Depends on kaac_pkg.
`timescale 1ns / 1ps

module kaac_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  kaac_pkg::out_item_t load_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output kaac_pkg::out_item_t out_data
);
  import kaac_pkg::*;

  logic      valid;
  out_item_t data;

  // Accepts a new result in the same cycle the held one is transferred.
  assign space     = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      data <= load_data;
    end
  end

endmodule

[bench/tb.sv]
// Testbench for keypad_alarm_access_controller: random and directed event streams,
// a behavioral predictor of the controller, and a checker on each result transfer.
// Depends on rtl/kaac_pkg.sv and rtl/keypad_alarm_access_controller.sv.
`timescale 1ns / 1ps

module tb;
  import kaac_pkg::*;

  localparam int CODE_LEN = 4;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int HOLD_AT = 200;
  localparam int HOLD_CYCLES = 150;

  // Event codes the block must ignore
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  keypad_alarm_access_controller #(.CODE_LENGTH(CODE_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted controller state
  mode_t       kp_mode = MODE_IDLE;
  lamp_t       kp_lamp = LAMP_OFF;
  phase_t      kp_phase = PH_IGNORE;
  logic [1:0]  kp_expiries = '0;
  logic [2:0]  kp_count = '0;
  logic [3:0]  kp_digits [MAX_DIGITS];
  logic [9:0]  kp_flash = FLASH_START_MS;
  logic        kp_sound = 1'b0;
  logic [15:0] code_reg = CODE_RESET;

  in_item_t  pending_events [$];
  out_item_t expected_results [$];

  int send_idle_pct = 28;
  int recv_idle_pct = 74;
  int queued_total = 0;
  int sent_count = 0;
  int checked_count = 0;
  int mismatch_count = 0;
  int grants = 0;
  int alarms = 0;
  int leaves = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic out_item_t step_keypad(input in_item_t ev);
    out_item_t r;
    bit        ok;
    int        i;
    r = '0;
    case (ev.action)
      ACT_ENTER: begin
        if (kp_mode == MODE_IDLE) begin
          kp_expiries = '0;
          kp_mode = MODE_CODE;
          kp_flash = FLASH_START_MS;
          kp_lamp = LAMP_FLASH;
          kp_phase = PH_INPUT;
          kp_count = '0;
          r.countdown_start = 1'b1;
          r.prompt_update = 1'b1;
        end
      end
      ACT_LEAVE: begin
        if (kp_mode == MODE_GRANTED) begin
          kp_mode = MODE_IDLE;
          kp_lamp = LAMP_OFF;
          r.leave_accepted = 1'b1;
        end
      end
      ACT_EXPIRE: begin
        if (kp_mode == MODE_CODE) begin
          if (kp_expiries < MAX_EXPIRY) begin
            kp_expiries = kp_expiries + 2'd1;
            r.countdown_start = 1'b1;
            kp_flash = (kp_flash >= FLASH_STEP_MS) ? kp_flash - FLASH_STEP_MS : '0;
          end else begin
            kp_mode = MODE_ALARM;
            kp_flash = FLASH_ALARM_MS;
            r.alarm_raise = 1'b1;
          end
        end
      end
      ACT_KEY: begin
        if (kp_phase == PH_INPUT) begin
          kp_digits[kp_count[DIG_IDX_W-1:0]] = ev.key_value;
          kp_count = kp_count + 3'd1;
          kp_sound = 1'b1;
          if (kp_count >= CODE_LEN) begin
            ok = 1'b1;
            for (i = 0; i < CODE_LEN && i < MAX_DIGITS; i++)
              if (kp_digits[i] != code_reg[4*i +: 4]) ok = 1'b0;
            if (ok) begin
              kp_mode = MODE_GRANTED;
              kp_lamp = LAMP_STEADY;
              kp_phase = PH_CODEBEEP;
              r.granted_message = 1'b1;
              r.sound_timer_cmd = SND_ONESHOT;
              r.sound_timer_ms = BEEP_CODE_MS;
            end else begin
              kp_phase = PH_ERRBEEP;
              kp_count = '0;
              r.prompt_update = 1'b1;
              r.sound_timer_cmd = SND_PERIODIC;
              r.sound_timer_ms = BEEP_ERR_MS;
            end
          end else begin
            kp_phase = PH_KEYBEEP;
            r.prompt_update = 1'b1;
            r.prompt_digits = kp_count;
            r.sound_timer_cmd = SND_ONESHOT;
            r.sound_timer_ms = BEEP_KEY_MS;
          end
        end
      end
      ACT_SOUND: begin
        if (kp_phase == PH_ERRBEEP) begin
          // error pattern toggles the sounder, stops after five timer periods
          kp_count = kp_count + 3'd1;
          kp_sound = ~kp_count[0];
          if (kp_count == ERR_BEEP_STEPS) begin
            r.sound_timer_cmd = SND_STOP;
            kp_phase = PH_INPUT;
            kp_count = '0;
          end
        end else if (kp_phase == PH_KEYBEEP) begin
          kp_sound = 1'b0;
          kp_phase = PH_INPUT;
        end else if (kp_phase == PH_CODEBEEP) begin
          kp_sound = 1'b0;
          kp_phase = PH_IGNORE;
        end
      end
      default: ;
    endcase
    r.mode_now = kp_mode;
    r.lamp_mode = kp_lamp;
    r.flash_interval_ms = kp_flash;
    r.sound_on = kp_sound;
    return r;
  endfunction

  task automatic check_result(input out_item_t want, input out_item_t got);
    bit bad;
    bad = (got.mode_now !== want.mode_now) || (got.lamp_mode !== want.lamp_mode) ||
          (got.flash_interval_ms !== want.flash_interval_ms) ||
          (got.sound_on !== want.sound_on) || (got.alarm_raise !== want.alarm_raise) ||
          (got.countdown_start !== want.countdown_start) ||
          (got.sound_timer_cmd !== want.sound_timer_cmd) ||
          (got.sound_timer_ms !== want.sound_timer_ms) ||
          (got.prompt_update !== want.prompt_update) ||
          (got.prompt_digits !== want.prompt_digits) ||
          (got.granted_message !== want.granted_message) ||
          (got.leave_accepted !== want.leave_accepted);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("tb: mismatch on result %0d at %0t (expected/actual):",
                 checked_count, $time);
        $display("tb:   mode %0d/%0d lamp %0d/%0d flash %0d/%0d sound %0b/%0b",
                 want.mode_now, got.mode_now, want.lamp_mode, got.lamp_mode,
                 want.flash_interval_ms, got.flash_interval_ms,
                 want.sound_on, got.sound_on);
        $display("tb:   alarm %0b/%0b cstart %0b/%0b snd_cmd %0d/%0d snd_ms %0d/%0d",
                 want.alarm_raise, got.alarm_raise,
                 want.countdown_start, got.countdown_start,
                 want.sound_timer_cmd, got.sound_timer_cmd,
                 want.sound_timer_ms, got.sound_timer_ms);
        $display("tb:   prompt %0b/%0b digits %0d/%0d granted %0b/%0b leave %0b/%0b",
                 want.prompt_update, got.prompt_update,
                 want.prompt_digits, got.prompt_digits,
                 want.granted_message, got.granted_message,
                 want.leave_accepted, got.leave_accepted);
      end
    end
  endtask

  // Input driver: predicts each event on its transfer
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        exp_r = step_keypad(in_data);
        expected_results.push_back(exp_r);
        sent_count++;
        if (exp_r.granted_message) grants++;
        if (exp_r.alarm_raise) alarms++;
        if (exp_r.leave_accepted) leaves++;
      end
      if (!in_valid || in_ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input
  always @(posedge clk) begin
    if (!rst && !hold_done && sent_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("tb: result transfer at %0t with nothing expected", $time);
        end else begin
          check_result(expected_results.pop_front(), out_data);
        end
        checked_count++;
      end
      if (hold_left != 0) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_event(input logic [2:0] act, input logic [3:0] key);
    in_item_t ev;
    ev.action = act;
    ev.key_value = key;
    pending_events.push_back(ev);
    queued_total++;
  endtask

  task automatic add_noise();
    add_event(3'($urandom_range(0, 7)), 4'($urandom));
  endtask

  // One visit: enter, maybe countdown expiries, code attempts, leave.
  task automatic queue_visit();
    int         n_exp;
    int         tries;
    int         t;
    int         d;
    bit         good;
    logic [3:0] k;
    add_event(ACT_ENTER, 4'($urandom));
    n_exp = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
    repeat (n_exp) add_event(ACT_EXPIRE, 4'($urandom));
    tries = $urandom_range(1, 3);
    for (t = 0; t < tries; t++) begin
      good = (t == tries - 1) ? ($urandom_range(4) != 0) : ($urandom_range(3) == 0);
      for (d = 0; d < CODE_LEN; d++) begin
        k = good ? code_reg[4*d +: 4] : 4'($urandom);
        if ($urandom_range(9) == 0) add_noise();
        add_event(ACT_KEY, k);
        // occasionally drop the beep expiry so the next key lands mid-beep
        if (d < CODE_LEN - 1 && $urandom_range(15) != 0) add_event(ACT_SOUND, 4'($urandom));
      end
      if (good) begin
        add_event(ACT_SOUND, 4'($urandom));
        break;
      end
      repeat (ERR_BEEP_STEPS) add_event(ACT_SOUND, 4'($urandom));
    end
    if ($urandom_range(4) == 0) add_noise();
    add_event(ACT_LEAVE, 4'($urandom));
  endtask

  task automatic queue_visits(input int count);
    int goal;
    goal = queued_total + count;
    while (queued_total < goal) queue_visit();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic write_access_code(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_ACCESS_CODE);
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    code_reg = value;
    @(negedge clk);
  endtask

  initial begin
    logic [15:0] rnd_code;
    rnd_code = 16'($urandom_range(1, 16'hFFFE));

    // Directed: ignored codes, wrong-state events, expiry ladder to alarm,
    // key during a beep, a wrong code and its full error pattern.
    add_event(ACT_SPARE_5, 4'hF);
    add_event(ACT_SPARE_6, 4'h5);
    add_event(ACT_SPARE_7, 4'h0);
    add_event(ACT_LEAVE, 4'h0);
    add_event(ACT_ENTER, 4'h0);
    add_event(ACT_ENTER, 4'hF);
    repeat (5) add_event(ACT_EXPIRE, 4'h0);
    add_event(ACT_KEY, 4'h1);
    add_event(ACT_KEY, 4'hF);
    add_event(ACT_SOUND, 4'h0);
    add_event(ACT_KEY, 4'h2);
    add_event(ACT_SOUND, 4'h0);
    add_event(ACT_KEY, 4'h3);
    add_event(ACT_SOUND, 4'h0);
    add_event(ACT_KEY, 4'h0);
    repeat (ERR_BEEP_STEPS + 1) add_event(ACT_SOUND, 4'hA);
    queue_visits(ITEMS_PER_PHASE);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait_drained();

    write_access_code(16'h0000);
    send_idle_pct = 74;
    recv_idle_pct = 28;
    queue_visits(ITEMS_PER_PHASE);
    wait_drained();

    write_access_code(16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_visits(ITEMS_PER_PHASE);
    wait_drained();

    // sender pauses mid-phase until all results are back
    write_access_code(rnd_code);
    queue_visits(ITEMS_PER_PHASE / 2);
    wait_drained();
    queue_visits(ITEMS_PER_PHASE / 2);
    wait_drained();

    repeat (8) @(posedge clk);
    $display("tb: %0d events sent, %0d results checked, %0d mismatches", sent_count,
             checked_count, mismatch_count);
    $display("tb: codes 4321/0000/ffff/%h, %0d grants, %0d alarms, %0d leaves", rnd_code,
             grants, alarms, leaves);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: timeout");
    $display("tb: FAIL");
    $finish;
  end

endmodule
